>>> sv/identity_registry_table_macros.svh
// assertion macros for the identity registry table
// used by the modules that carry concurrent checks; no other dependencies
`ifndef IDENTITY_REGISTRY_TABLE_MACROS_SVH
`define IDENTITY_REGISTRY_TABLE_MACROS_SVH
`ifndef SYNTH
`define IRT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("irt check failed");
`define IRT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("irt check failed");
`else
`define IRT_ASSERT(lbl, prop)
`define IRT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> sv/irt_pkg.sv
// shared types, codes and constants of the identity registry table
// no dependencies
`timescale 1ns / 1ps
package irt_pkg;
    localparam int DEPTH    = 64;
    localparam int IDX_W    = 6;
    localparam int PTR_W    = IDX_W + 1;
    localparam int HANDLE_W = 16;
    localparam logic [IDX_W-1:0] ID_MAX = IDX_W'(DEPTH - 1);

    localparam logic [3:0] OP_ASSIGN   = 4'd0;
    localparam logic [3:0] OP_UNASSIGN = 4'd1;
    localparam logic [3:0] OP_GET      = 4'd2;
    localparam logic [3:0] OP_NEXT     = 4'd3;
    localparam logic [3:0] OP_PREV     = 4'd4;
    localparam logic [3:0] OP_FIRST    = 4'd5;
    localparam logic [3:0] OP_LAST     = 4'd6;
    localparam logic [3:0] OP_FREE     = 4'd7;
    localparam logic [3:0] OP_COUNT    = 4'd8;
    localparam logic [3:0] OP_COMPACT  = 4'd9;
    localparam logic [3:0] OP_CLEAR    = 4'd10;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    typedef struct packed {
        logic [3:0]          operation;
        logic [IDX_W-1:0]    identity;
        logic [HANDLE_W-1:0] handle;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    result_id;
        logic [HANDLE_W-1:0] result_handle;
        logic [IDX_W-1:0]    old_id;
        logic                last;
    } t_out;

    typedef enum logic [2:0] {
        P_ID, P_ID1, P_IDM1, P_HI1, P_HI, P_LOW, P_ONE
    } t_ptr_sel;

    typedef enum logic [3:0] {
        E_ERR, E_FOUND, E_NEW, E_UNA, E_ID, E_CNT, E_ZERO, E_MOVE, E_FINAL
    } t_emit;

    typedef struct packed {
        logic       load;
        logic       ptr_ld;
        t_ptr_sel   psel;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       rd;
        logic       do_assign;
        logic       do_unassign;
        logic       low_ld_ptr;
        logic       do_clear;
        logic       cmove;
        logic       dst_inc;
        logic       dst_ld1;
        logic       cfinal;
        logic       emit;
        t_emit      ekind;
        logic [1:0] estat;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       id_zero;
        logic       hi_full;
        logic       occ_id;
        logic       id_le_hi;
        logic       low_lt_id;
        logic       low_valid;
        logic       hi_zero;
        logic       occ_hi;
        logic       occ_ptr;
        logic       ptr_gt_hi;
        logic       ptr_end;
        logic       ptr_zero;
        logic       ptr_eq_dst;
        logic       ptr_eq_low;
        logic       hmatch;
        logic       out_free;
    } t_dp_sts;
endpackage

>>> sv/irt_datapath.sv
// datapath of the identity registry table: occupancy bits, handle memory,
// scan pointers, bookkeeping registers and output register; uses irt_pkg
`timescale 1ns / 1ps
`include "identity_registry_table_macros.svh"
module irt_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  irt_pkg::t_in     i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output irt_pkg::t_out    o_data,
    input  irt_pkg::t_dp_cmd i_cmd,
    output irt_pkg::t_dp_sts o_sts
);
    import irt_pkg::*;

    logic [3:0]          r_op;
    logic [IDX_W-1:0]    r_id;
    logic [HANDLE_W-1:0] r_h;
    logic [DEPTH-1:0]    r_occ;
    logic [HANDLE_W-1:0] r_mem [DEPTH];
    logic [HANDLE_W-1:0] r_rd;
    logic [PTR_W-1:0]    r_low;
    logic [IDX_W-1:0]    r_hi;
    logic [PTR_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    r_ptr;
    logic [PTR_W-1:0]    r_dst;
    logic                r_ovalid;
    t_out                r_out;

    logic [PTR_W-1:0]    n_ptr;
    logic [PTR_W-1:0]    dst_m1;
    logic                out_free;
    t_out                n_out;

    assign dst_m1   = r_dst - PTR_W'(1);
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        case (i_cmd.psel)
            P_ID:    n_ptr = {1'b0, r_id};
            P_ID1:   n_ptr = {1'b0, r_id} + PTR_W'(1);
            P_IDM1:  n_ptr = {1'b0, r_id} - PTR_W'(1);
            P_HI1:   n_ptr = {1'b0, r_hi} + PTR_W'(1);
            P_HI:    n_ptr = {1'b0, r_hi};
            P_LOW:   n_ptr = r_low;
            P_ONE:   n_ptr = PTR_W'(1);
            default: n_ptr = PTR_W'(1);
        endcase
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.id_zero    = (r_id == '0);
        o_sts.hi_full    = (r_hi == ID_MAX);
        o_sts.occ_id     = r_occ[r_id];
        o_sts.id_le_hi   = (r_id <= r_hi);
        o_sts.low_lt_id  = (r_low < {1'b0, r_id});
        o_sts.low_valid  = !r_low[PTR_W-1] && r_occ[r_low[IDX_W-1:0]];
        o_sts.hi_zero    = (r_hi == '0);
        o_sts.occ_hi     = r_occ[r_hi];
        o_sts.occ_ptr    = r_occ[r_ptr[IDX_W-1:0]];
        o_sts.ptr_gt_hi  = (r_ptr > {1'b0, r_hi});
        o_sts.ptr_end    = r_ptr[PTR_W-1];
        o_sts.ptr_zero   = (r_ptr == '0);
        o_sts.ptr_eq_dst = (r_ptr == r_dst);
        o_sts.ptr_eq_low = (r_ptr == r_low);
        o_sts.hmatch     = (r_rd == r_h);
        o_sts.out_free   = out_free;
    end

    // result beat assembly
    always_comb begin
        n_out        = '0;
        n_out.last   = 1'b1;
        case (i_cmd.ekind)
            E_ERR:   n_out.status = i_cmd.estat;
            E_FOUND: begin
                n_out.result_id     = r_ptr[IDX_W-1:0];
                n_out.result_handle = r_rd;
            end
            E_NEW: begin
                n_out.result_id     = r_ptr[IDX_W-1:0];
                n_out.result_handle = r_h;
            end
            E_UNA: begin
                n_out.result_id     = r_id;
                n_out.result_handle = r_h;
            end
            E_ID:    n_out.result_id = r_ptr[IDX_W-1:0];
            E_CNT:   n_out.result_id = r_cnt[IDX_W-1:0];
            E_ZERO:  n_out.result_id = '0;
            E_MOVE: begin
                n_out.result_id     = r_dst[IDX_W-1:0];
                n_out.result_handle = r_rd;
                n_out.old_id        = r_ptr[IDX_W-1:0];
                n_out.last          = 1'b0;
            end
            E_FINAL: n_out.result_id = dst_m1[IDX_W-1:0];
            default: n_out.status = ST_NONE;
        endcase
    end

    // handle memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_assign) begin
            r_mem[r_ptr[IDX_W-1:0]] <= r_h;
        end else if (i_cmd.cmove) begin
            r_mem[r_dst[IDX_W-1:0]] <= r_rd;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_ptr[IDX_W-1:0]];
        end
    end

    // payload, pointer and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_data.operation;
            r_id <= i_data.identity;
            r_h  <= i_data.handle;
        end
        if (i_cmd.ptr_ld) begin
            r_ptr <= n_ptr;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - PTR_W'(1);
        end
        if (i_cmd.dst_ld1) begin
            r_dst <= PTR_W'(1);
        end else if (i_cmd.dst_inc) begin
            r_dst <= r_dst + PTR_W'(1);
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_low    <= PTR_W'(DEPTH);
            r_hi     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.do_assign) begin
                r_occ[r_ptr[IDX_W-1:0]] <= 1'b1;
                r_cnt <= r_cnt + PTR_W'(1);
                if (r_ptr > {1'b0, r_hi}) begin
                    r_hi <= r_ptr[IDX_W-1:0];
                end
                if (r_ptr < r_low) begin
                    r_low <= r_ptr;
                end
            end
            if (i_cmd.do_unassign) begin
                r_occ[r_ptr[IDX_W-1:0]] <= 1'b0;
                r_cnt <= r_cnt - PTR_W'(1);
                if (r_ptr == r_low) begin
                    r_low <= PTR_W'(DEPTH);
                end
            end
            if (i_cmd.low_ld_ptr) begin
                r_low <= r_ptr;
            end
            if (i_cmd.cmove) begin
                r_occ[r_dst[IDX_W-1:0]] <= 1'b1;
                r_occ[r_ptr[IDX_W-1:0]] <= 1'b0;
                // lowest entry moved down: follow it
                if (r_ptr == r_low) begin
                    r_low <= r_dst;
                end
            end
            if (i_cmd.cfinal) begin
                r_hi  <= dst_m1[IDX_W-1:0];
                r_cnt <= dst_m1;
                r_low <= (dst_m1 == '0) ? PTR_W'(DEPTH) : PTR_W'(1);
            end
            if (i_cmd.do_clear) begin
                r_occ <= '0;
                r_low <= PTR_W'(DEPTH);
                r_hi  <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    `IRT_ASSERT(a_emit_free, !i_cmd.emit || out_free)
    `IRT_ASSERT(a_assign_empty, !i_cmd.do_assign || !r_occ[r_ptr[IDX_W-1:0]])
    `IRT_ASSERT(a_move_down, !i_cmd.cmove || (r_dst < r_ptr))
    `IRT_ASSERT(a_low_occupied, r_low[PTR_W-1] || r_occ[r_low[IDX_W-1:0]] || i_cmd.do_unassign)
endmodule

>>> sv/irt_ctrl.sv
// controller of the identity registry table: decodes the operation and
// sequences lookups, scans and compaction; uses irt_pkg
`timescale 1ns / 1ps
`include "identity_registry_table_macros.svh"
module irt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  irt_pkg::t_dp_sts i_sts,
    output irt_pkg::t_dp_cmd o_cmd
);
    import irt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_ASN    = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_CREAD  = 8'b0100_0000,
        S_CMOVE  = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        M_FIND, M_ASN, M_UNA, M_NEXT, M_PREV, M_FREE, M_LOW, M_CMP
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_dp_cmd c;

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = c;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        c       = '0;
        c.psel  = P_ONE;
        c.ekind = E_ERR;
        c.estat = ST_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    c.load  = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    case (i_sts.op)
                        OP_ASSIGN: begin
                            if (i_sts.id_zero && i_sts.hi_full) begin
                                c.emit  = 1'b1;
                                c.estat = ST_CAPACITY;
                            end else begin
                                c.ptr_ld = 1'b1;
                                c.psel   = i_sts.id_zero ? P_HI1 : P_ID;
                                n_state  = S_ASN;
                            end
                        end
                        OP_UNASSIGN: begin
                            if (i_sts.id_zero) begin
                                c.emit  = 1'b1;
                                c.ekind = E_ZERO;
                            end else if (!i_sts.id_le_hi || !i_sts.occ_id) begin
                                c.emit  = 1'b1;
                                c.estat = ST_CONFLICT;
                            end else begin
                                c.ptr_ld = 1'b1;
                                c.psel   = P_ID;
                                n_mode   = M_UNA;
                                n_state  = S_READ;
                            end
                        end
                        OP_GET: begin
                            if (i_sts.id_le_hi && i_sts.occ_id) begin
                                c.ptr_ld = 1'b1;
                                c.psel   = P_ID;
                                n_mode   = M_FIND;
                                n_state  = S_READ;
                            end else begin
                                c.emit = 1'b1;
                            end
                        end
                        OP_NEXT: begin
                            c.ptr_ld = 1'b1;
                            c.psel   = P_ID1;
                            n_mode   = M_NEXT;
                            n_state  = S_SCAN;
                        end
                        OP_PREV: begin
                            if (i_sts.low_lt_id) begin
                                c.ptr_ld = 1'b1;
                                c.psel   = P_IDM1;
                                n_mode   = M_PREV;
                                n_state  = S_SCAN;
                            end else begin
                                c.emit = 1'b1;
                            end
                        end
                        OP_FIRST: begin
                            if (i_sts.low_valid) begin
                                c.ptr_ld = 1'b1;
                                c.psel   = P_LOW;
                                n_mode   = M_FIND;
                                n_state  = S_READ;
                            end else begin
                                c.emit = 1'b1;
                            end
                        end
                        OP_LAST: begin
                            if (i_sts.hi_zero) begin
                                c.emit = 1'b1;
                            end else if (i_sts.occ_hi) begin
                                c.ptr_ld = 1'b1;
                                c.psel   = P_HI;
                                n_mode   = M_FIND;
                                n_state  = S_READ;
                            end else begin
                                c.emit  = 1'b1;
                                c.estat = ST_CONFLICT;
                            end
                        end
                        OP_FREE: begin
                            c.ptr_ld = 1'b1;
                            c.psel   = P_ONE;
                            n_mode   = M_FREE;
                            n_state  = S_SCAN;
                        end
                        OP_COUNT: begin
                            c.emit  = 1'b1;
                            c.ekind = E_CNT;
                        end
                        OP_COMPACT: begin
                            c.ptr_ld  = 1'b1;
                            c.psel    = P_ONE;
                            c.dst_ld1 = 1'b1;
                            n_mode    = M_CMP;
                            n_state   = S_SCAN;
                        end
                        OP_CLEAR: begin
                            c.do_clear = 1'b1;
                            c.emit     = 1'b1;
                            c.ekind    = E_ZERO;
                        end
                        default: begin
                            c.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_ASN: begin
                if (i_sts.occ_ptr && !i_sts.id_zero) begin
                    n_mode  = M_ASN;
                    n_state = S_READ;
                end else if (i_sts.out_free) begin
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.occ_ptr) begin
                        c.estat = ST_CONFLICT;
                    end else begin
                        c.do_assign = 1'b1;
                        c.ekind     = E_NEW;
                    end
                end
            end
            S_READ: begin
                c.rd    = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    case (r_mode)
                        M_ASN: begin
                            c.emit = 1'b1;
                            if (i_sts.hmatch) begin
                                c.ekind = E_FOUND;
                            end else begin
                                c.estat = ST_CONFLICT;
                            end
                        end
                        M_UNA: begin
                            if (!i_sts.hmatch) begin
                                c.emit  = 1'b1;
                                c.estat = ST_CONFLICT;
                            end else begin
                                c.do_unassign = 1'b1;
                                if (i_sts.ptr_eq_low) begin
                                    // lowest went away: rescan upward
                                    c.ptr_ld = 1'b1;
                                    c.psel   = P_ID1;
                                    n_mode   = M_LOW;
                                    n_state  = S_SCAN;
                                end else begin
                                    c.emit  = 1'b1;
                                    c.ekind = E_UNA;
                                end
                            end
                        end
                        default: begin
                            c.emit  = 1'b1;
                            c.ekind = E_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (r_mode)
                    M_NEXT: begin
                        if (i_sts.ptr_gt_hi) begin
                            if (i_sts.out_free) begin
                                c.emit  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (i_sts.occ_ptr) begin
                            n_mode  = M_FIND;
                            n_state = S_READ;
                        end else begin
                            c.ptr_inc = 1'b1;
                        end
                    end
                    M_PREV: begin
                        if (i_sts.ptr_zero) begin
                            if (i_sts.out_free) begin
                                c.emit  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (i_sts.occ_ptr) begin
                            n_mode  = M_FIND;
                            n_state = S_READ;
                        end else begin
                            c.ptr_dec = 1'b1;
                        end
                    end
                    M_FREE: begin
                        if (i_sts.ptr_end || !i_sts.occ_ptr) begin
                            if (i_sts.out_free) begin
                                c.emit  = 1'b1;
                                c.ekind = i_sts.ptr_end ? E_ERR : E_ID;
                                n_state = S_IDLE;
                            end
                        end else begin
                            c.ptr_inc = 1'b1;
                        end
                    end
                    M_LOW: begin
                        if (i_sts.ptr_gt_hi || i_sts.occ_ptr) begin
                            if (i_sts.out_free) begin
                                c.low_ld_ptr = !i_sts.ptr_gt_hi;
                                c.emit       = 1'b1;
                                c.ekind      = E_UNA;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            c.ptr_inc = 1'b1;
                        end
                    end
                    M_CMP: begin
                        if (i_sts.ptr_end) begin
                            if (i_sts.out_free) begin
                                c.cfinal = 1'b1;
                                c.emit   = 1'b1;
                                c.ekind  = E_FINAL;
                                n_state  = S_IDLE;
                            end
                        end else if (!i_sts.occ_ptr) begin
                            c.ptr_inc = 1'b1;
                        end else if (i_sts.ptr_eq_dst) begin
                            c.ptr_inc = 1'b1;
                            c.dst_inc = 1'b1;
                        end else begin
                            n_state = S_CREAD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CREAD: begin
                c.rd    = 1'b1;
                n_state = S_CMOVE;
            end
            S_CMOVE: begin
                if (i_sts.out_free) begin
                    c.cmove   = 1'b1;
                    c.emit    = 1'b1;
                    c.ekind   = E_MOVE;
                    c.ptr_inc = 1'b1;
                    c.dst_inc = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_FIND;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    `IRT_ASSERT(a_state_onehot, $onehot(r_state))
    `IRT_ASSERT_NEXT(a_load_decode, c.load, r_state == S_DECODE)
    `IRT_ASSERT_NEXT(a_read_check, r_state == S_READ, r_state == S_CHECK)
endmodule

>>> sv/identity_registry_table.sv
// top level of the identity registry table
// joins irt_ctrl and irt_datapath; uses irt_pkg
`timescale 1ns / 1ps
// identity registry table: maps identities 1..63 to 16-bit object handles,
// keeping the lowest occupied identity, the highest identity issued since
// the last clear or compact and the entry count. one input beat carries an
// operation (assign, unassign, get, next, previous, first, last, first-free,
// count, compact, clear); each gives one result beat with last set, except
// compact, which gives one move beat per relocated entry and then a final
// beat. items are handled one at a time: o_stall is high from the accepted
// beat until the item's last result sits in the output register. count and
// clear finish at decode, get/first/last decode and read the handle memory,
// assign compares the stored handle when a given identity is taken; next,
// previous, first-free and the lowest-rescan after an unassign walk the
// occupancy bits one identity per cycle. compact walks all 63 identities
// once, with a memory read then a write per moved entry. handles live in a
// single-port-write, registered-read memory; occupancy is a flip-flop bit
// per identity, cleared by reset and by clear. the result register lets the
// next beat be taken while the last result still waits downstream
module identity_registry_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  irt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output irt_pkg::t_out o_data
);
    import irt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing: decode, scans, compaction steps
    irt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage, pointers and result beat
    irt_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

>>> test/tb_identity_registry_table.sv
// self-checking testbench for the identity registry table
// depends on irt_pkg and identity_registry_table; predicts every result beat in-line
`timescale 1ns / 1ps
module tb_identity_registry_table;
    import irt_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    identity_registry_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // predictor copy of the table
    logic                 tbl_occ [DEPTH];
    logic [HANDLE_W-1:0]  tbl_handle [DEPTH];
    int unsigned          tbl_low;
    int unsigned          tbl_high;
    int unsigned          tbl_count;

    t_in   pending_items[$];
    t_out  expected_beats[$];

    int    mismatches;
    int    beats_seen;
    int    items_sent;
    int    compacts_sent;
    bit    stim_done;
    bit    hold_long;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // final fallback if the block hangs
    initial begin
        #20ms;
        $display("tb_identity_registry_table NOT OK");
        $finish;
    end

    function automatic t_out make_beat(logic [1:0] st, int unsigned id,
                                       logic [HANDLE_W-1:0] h, int unsigned old,
                                       logic fin);
        t_out b;
        b.status        = st;
        b.result_id     = (st == ST_OK) ? IDX_W'(id) : '0;
        b.result_handle = (st == ST_OK) ? h : '0;
        b.old_id        = IDX_W'(old);
        b.last          = fin;
        return b;
    endfunction

    function automatic void table_clear();
        for (int k = 0; k < DEPTH; k++) tbl_occ[k] = 1'b0;
        tbl_low   = DEPTH;
        tbl_high  = 0;
        tbl_count = 0;
    endfunction

    // works out the result beats of one accepted item and updates the table
    task automatic predict_registry(t_in it);
        int unsigned id;
        int unsigned n;
        int unsigned dst;
        logic [HANDLE_W-1:0] h;
        bit hit;
        id  = it.identity;
        h   = it.handle;
        hit = 0;
        case (it.operation)
            OP_ASSIGN: begin
                if (id == 0 && tbl_high + 1 >= DEPTH) begin
                    expected_beats.push_back(make_beat(ST_CAPACITY, 0, 0, 0, 1));
                end else if (id != 0 && tbl_occ[id]) begin
                    // same handle again is fine, another handle is a conflict
                    if (tbl_handle[id] == h)
                        expected_beats.push_back(make_beat(ST_OK, id, h, 0, 1));
                    else
                        expected_beats.push_back(make_beat(ST_CONFLICT, 0, 0, 0, 1));
                end else begin
                    n = (id == 0) ? tbl_high + 1 : id;
                    if (tbl_occ[n]) begin
                        expected_beats.push_back(make_beat(ST_CONFLICT, 0, 0, 0, 1));
                    end else begin
                        tbl_occ[n]    = 1'b1;
                        tbl_handle[n] = h;
                        tbl_count++;
                        if (n > tbl_high) tbl_high = n;
                        if (n < tbl_low)  tbl_low  = n;
                        expected_beats.push_back(make_beat(ST_OK, n, h, 0, 1));
                    end
                end
            end
            OP_UNASSIGN: begin
                if (id == 0) begin
                    expected_beats.push_back(make_beat(ST_OK, 0, 0, 0, 1));
                end else if (id > tbl_high || !tbl_occ[id] || tbl_handle[id] != h) begin
                    expected_beats.push_back(make_beat(ST_CONFLICT, 0, 0, 0, 1));
                end else begin
                    tbl_occ[id] = 1'b0;
                    tbl_count--;
                    if (id == tbl_low) begin
                        // rescan upward for the new lowest
                        tbl_low = DEPTH;
                        for (n = id + 1; n <= tbl_high && n < DEPTH; n++)
                            if (tbl_occ[n]) begin
                                tbl_low = n;
                                break;
                            end
                    end
                    expected_beats.push_back(make_beat(ST_OK, id, h, 0, 1));
                end
            end
            OP_GET: begin
                if (id <= tbl_high && tbl_occ[id])
                    expected_beats.push_back(make_beat(ST_OK, id, tbl_handle[id], 0, 1));
                else
                    expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
            end
            OP_NEXT: begin
                for (n = id + 1; n <= tbl_high && n < DEPTH; n++)
                    if (tbl_occ[n]) begin
                        expected_beats.push_back(make_beat(ST_OK, n, tbl_handle[n], 0, 1));
                        hit = 1;
                        break;
                    end
                if (!hit) expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
            end
            OP_PREV: begin
                if (tbl_low < id) begin
                    for (int k = int'(id) - 1; k >= 0; k--)
                        if (tbl_occ[k]) begin
                            expected_beats.push_back(
                                make_beat(ST_OK, k, tbl_handle[k], 0, 1));
                            hit = 1;
                            break;
                        end
                end
                if (!hit) expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
            end
            OP_FIRST: begin
                if (tbl_low < DEPTH && tbl_occ[tbl_low])
                    expected_beats.push_back(
                        make_beat(ST_OK, tbl_low, tbl_handle[tbl_low], 0, 1));
                else
                    expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
            end
            OP_LAST: begin
                if (tbl_high == 0)
                    expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
                else if (tbl_occ[tbl_high])
                    expected_beats.push_back(
                        make_beat(ST_OK, tbl_high, tbl_handle[tbl_high], 0, 1));
                else
                    expected_beats.push_back(make_beat(ST_CONFLICT, 0, 0, 0, 1));
            end
            OP_FREE: begin
                for (n = 1; n < DEPTH; n++)
                    if (!tbl_occ[n]) begin
                        expected_beats.push_back(make_beat(ST_OK, n, 0, 0, 1));
                        hit = 1;
                        break;
                    end
                if (!hit) expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
            end
            OP_COUNT: expected_beats.push_back(make_beat(ST_OK, tbl_count, 0, 0, 1));
            OP_COMPACT: begin
                dst = 1;
                for (n = 1; n < DEPTH; n++) begin
                    if (tbl_occ[n]) begin
                        if (n != dst) begin
                            tbl_occ[dst]    = 1'b1;
                            tbl_handle[dst] = tbl_handle[n];
                            tbl_occ[n]      = 1'b0;
                            expected_beats.push_back(
                                make_beat(ST_OK, dst, tbl_handle[dst], n, 0));
                        end
                        dst++;
                    end
                end
                tbl_high  = dst - 1;
                tbl_count = dst - 1;
                tbl_low   = (tbl_count != 0) ? 1 : DEPTH;
                expected_beats.push_back(make_beat(ST_OK, tbl_high, 0, 0, 1));
            end
            OP_CLEAR: begin
                table_clear();
                expected_beats.push_back(make_beat(ST_OK, 0, 0, 0, 1));
            end
            default: expected_beats.push_back(make_beat(ST_NONE, 0, 0, 0, 1));
        endcase
    endtask

    function automatic t_in mk(logic [3:0] op, int unsigned id, int unsigned h);
        t_in it;
        it.operation = op;
        it.identity  = IDX_W'(id);
        it.handle    = HANDLE_W'(h);
        return it;
    endfunction

    // stimulus shadow: which identities the stimulus believes are in use, so that
    // most unassigns carry the matching handle
    logic [HANDLE_W-1:0] shadow_h [DEPTH];
    logic                shadow_v [DEPTH];

    function automatic t_in random_item();
        t_in it;
        int unsigned pick;
        int unsigned id;
        pick = $urandom_range(0, 99);
        id   = $urandom_range(0, 63);
        if (pick < 30) begin
            // assign, mostly auto-issued
            it = mk(OP_ASSIGN, ($urandom_range(0, 2) == 0) ? id : 0, $urandom);
        end else if (pick < 50) begin
            // unassign, mostly with the matching handle
            if (shadow_v[id] && $urandom_range(0, 4) != 0)
                it = mk(OP_UNASSIGN, id, shadow_h[id]);
            else
                it = mk(OP_UNASSIGN, id, $urandom);
        end else if (pick < 97) begin
            it = mk(4'($urandom_range(OP_GET, OP_COUNT)), id, $urandom);
        end else if (pick < 98) begin
            it = mk(OP_COMPACT, id, $urandom);
        end else if (pick < 99) begin
            it = mk(OP_CLEAR, id, $urandom);
        end else begin
            // codes beyond clear
            it = mk(4'($urandom_range(11, 15)), id, $urandom);
        end
        return it;
    endfunction

    // driver: bursts of random length with random gaps, changes at falling edge
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (i_valid && o_stall) begin
            // payload holds while stalled
        end else begin
            // the beat on the bus was taken: drop it, the next one is at the front
            if (i_valid && pending_items.size() != 0) void'(pending_items.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_valid <= 1'b1;
                i_data  <= pending_items[0];
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off counted here
    int stall_phase;
    int hold_count;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_phase <= 0;
            hold_count  <= 0;
        end else if (hold_long && hold_count < 400) begin
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            stall_phase <= stall_phase + 1;
            // quiet stretches alternate with busy stalling ones
            if (stall_phase[8])
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // monitor: predicts on accepted input beats, checks accepted result beats
    always @(posedge i_clk) begin
        t_out exp_beat;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_registry(i_data);
                items_sent++;
                if (i_data.operation == OP_COMPACT) compacts_sent++;
            end
            if (o_valid && !i_stall) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", o_data);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (o_data !== exp_beat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_beat, o_data);
                    end
                end
            end
        end
    end

    task automatic queue_item(t_in it);
        pending_items.push_back(it);
        if (it.operation == OP_ASSIGN && it.identity != 0) begin
            shadow_v[it.identity] = 1'b1;
            shadow_h[it.identity] = it.handle;
        end
    endtask

    initial begin
        int cnt;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_data        = '0;
        mismatches    = 0;
        beats_seen    = 0;
        items_sent    = 0;
        compacts_sent = 0;
        stim_done     = 0;
        hold_long     = 0;
        table_clear();
        for (int k = 0; k < DEPTH; k++) begin
            shadow_v[k] = 0;
            shadow_h[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-table lookups, extremes, conflicts and corner cases
        queue_item(mk(OP_FIRST, 0, 0));
        queue_item(mk(OP_LAST, 0, 0));
        queue_item(mk(OP_PREV, 63, 0));
        queue_item(mk(OP_UNASSIGN, 0, 16'hFFFF));
        queue_item(mk(OP_ASSIGN, 0, 16'hFFFF));
        queue_item(mk(OP_ASSIGN, 63, 16'h0000));
        queue_item(mk(OP_ASSIGN, 63, 16'h0000));   // same handle again
        queue_item(mk(OP_ASSIGN, 63, 16'h5A5A));   // slot taken by another
        queue_item(mk(OP_ASSIGN, 0, 16'h1234));    // issue past the end
        queue_item(mk(OP_UNASSIGN, 63, 16'h1111)); // wrong handle
        queue_item(mk(OP_GET, 63, 0));
        queue_item(mk(OP_NEXT, 0, 0));
        queue_item(mk(OP_NEXT, 63, 0));
        queue_item(mk(OP_PREV, 63, 0));
        queue_item(mk(OP_ASSIGN, 30, 16'hA5A5));
        queue_item(mk(OP_UNASSIGN, 1, 16'hFFFF));  // lowest leaves, rescan
        queue_item(mk(OP_FIRST, 0, 0));
        queue_item(mk(OP_UNASSIGN, 63, 16'h0000)); // top slot now empty
        queue_item(mk(OP_LAST, 0, 0));
        queue_item(mk(OP_FREE, 0, 0));
        queue_item(mk(OP_COUNT, 0, 0));
        queue_item(mk(OP_COMPACT, 0, 0));
        queue_item(mk(4'd15, 5, 16'h0F0F));
        queue_item(mk(OP_CLEAR, 0, 0));
        queue_item(mk(OP_COMPACT, 0, 0));          // compact on empty table
        // fill the table completely for a full first-free
        for (int k = 0; k < 63; k++) queue_item(mk(OP_ASSIGN, 0, $urandom));
        queue_item(mk(OP_FREE, 0, 0));
        queue_item(mk(OP_COUNT, 0, 0));
        queue_item(mk(OP_UNASSIGN, 10, 0));
        queue_item(mk(OP_COMPACT, 0, 0));
        queue_item(mk(OP_CLEAR, 0, 0));
        for (int k = 0; k < DEPTH; k++) shadow_v[k] = 0;

        // random part; long receiver hold-off partway through
        for (int k = 0; k < 310; k++) begin
            queue_item(random_item());
            if (k == 150) hold_long = 1;
            while (pending_items.size() > 8) @(posedge i_clk);
        end
        while (pending_items.size() != 0 || i_valid) @(posedge i_clk);
        stim_done = 1;

        cnt = 0;
        while (expected_beats.size() != 0 && cnt < 100000) begin
            @(posedge i_clk);
            cnt++;
        end
        repeat (250) @(posedge i_clk);

        $display("covered %0d items (%0d compacts) and %0d result beats",
                 items_sent, compacts_sent, beats_seen);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("tb_identity_registry_table OK");
        end else begin
            $display("%0d mismatches, %0d beats still expected",
                     mismatches, expected_beats.size());
            $display("tb_identity_registry_table NOT OK");
        end
        $finish;
    end
endmodule

>>> identity_registry_table.f
+incdir+sv
sv/irt_pkg.sv
sv/irt_datapath.sv
sv/irt_ctrl.sv
sv/identity_registry_table.sv
test/tb_identity_registry_table.sv
